// ----- rtl/core/vpci_pkg.sv -----
// Package for the vector path command interpreter.
// Holds token codes, result kinds and the queue entry type. No dependencies.
package vpci_pkg;

  localparam int ArgCount = 7;

  typedef enum logic [1:0] {
    OP_LETTER = 2'd0,
    OP_NUMBER = 2'd1,
    OP_END    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [3:0] LET_M = 4'd0;
  localparam logic [3:0] LET_L = 4'd1;
  localparam logic [3:0] LET_H = 4'd2;
  localparam logic [3:0] LET_V = 4'd3;
  localparam logic [3:0] LET_Q = 4'd4;
  localparam logic [3:0] LET_T = 4'd5;
  localparam logic [3:0] LET_C = 4'd6;
  localparam logic [3:0] LET_S = 4'd7;
  localparam logic [3:0] LET_A = 4'd8;
  localparam logic [3:0] LET_Z = 4'd9;

  localparam logic [3:0] KIND_BEGIN  = 4'd0;
  localparam logic [3:0] KIND_LINE   = 4'd1;
  localparam logic [3:0] KIND_QUAD   = 4'd2;
  localparam logic [3:0] KIND_CUBIC  = 4'd3;
  localparam logic [3:0] KIND_ARC    = 4'd4;
  localparam logic [3:0] KIND_OPEN   = 4'd5;
  localparam logic [3:0] KIND_CLOSED = 4'd6;
  localparam logic [3:0] KIND_DONE   = 4'd7;
  localparam logic [3:0] KIND_ERROR  = 4'd8;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  letter;
    logic        relative;
    logic [31:0] number;
  } token_t;

  function automatic logic [2:0] arg_need(input logic [3:0] ltr);
    case (ltr)
      LET_M, LET_L, LET_T: arg_need = 3'd2;
      LET_H, LET_V:        arg_need = 3'd1;
      LET_Q, LET_S:        arg_need = 3'd4;
      LET_C:               arg_need = 3'd6;
      LET_A:               arg_need = 3'd7;
      default:             arg_need = 3'd0;
    endcase
  endfunction

endpackage

// ----- rtl/core/vpci_front.sv -----
// Input side of the path interpreter: registers accepted tokens in a two-word queue.
// Depends on vpci_pkg.
module vpci_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  vpci_pkg::token_t in_tok,
  output logic            q_valid,
  input  logic            q_take,
  output vpci_pkg::token_t q_tok
);
  import vpci_pkg::*;

  token_t     entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_tok    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_tok;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_take};
    end
  end

endmodule

// ----- rtl/core/vpci_back.sv -----
// Execution side: gathers arguments, tracks path state, emits up to two results
// per token through a registered output with a one-entry spill. Depends on vpci_pkg.
module vpci_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_take,
  input  vpci_pkg::token_t q_tok,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       kind,
  output logic [31:0]      x0,
  output logic [31:0]      y0,
  output logic [31:0]      x1,
  output logic [31:0]      y1,
  output logic [31:0]      x2,
  output logic [31:0]      y2,
  output logic             large_arc,
  output logic             sweep,
  output logic             last
);
  import vpci_pkg::*;

  localparam int CW = COORD_WIDTH;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] x0, y0, x1, y1, x2, y2;
    logic        la, sw, last;
  } res_t;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] cur_x, cur_y, ctl_x, ctl_y, st_x, st_y;
  logic signed [CW-1:0] args [ArgCount];
  logic [3:0]  act_let, prev_let;
  logic        act_rel, act_on, prev_on, prev_rel;
  logic [2:0]  gathered;
  logic        in_fig, halted;

  res_t        ob, spill;
  logic        ob_v, spill_v;

  function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
    if (v > $signed({{2{CMAX[CW-1]}}, CMAX})) sat = CMAX;
    else if (v < $signed({{2{CMIN[CW-1]}}, CMIN})) sat = CMIN;
    else sat = v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] reladd(input logic signed [CW-1:0] v,
      input logic signed [CW-1:0] b, input logic r);
    if (r) reladd = sat({{2{v[CW-1]}}, v} + {{2{b[CW-1]}}, b});
    else reladd = v;
  endfunction

  function automatic logic signed [CW-1:0] refl(input logic signed [CW-1:0] c,
      input logic signed [CW-1:0] p);
    refl = sat(({{2{c[CW-1]}}, c} <<< 1) - {{2{p[CW-1]}}, p});
  endfunction

  function automatic logic [31:0] lo32(input logic signed [CW-1:0] v);
    logic signed [CW+31:0] e;
    e = {{32{v[CW-1]}}, v};
    lo32 = e[31:0];
  endfunction

  function automatic res_t mk(input logic [3:0] k);
    mk = '0;
    mk.kind = k;
  endfunction

  // Number saturated into the coordinate range, which may be narrower or wider
  // than the 32-bit input.
  logic signed [CW-1:0] num_c;
  always_comb begin
    logic signed [CW+33:0] ne;
    ne = {{(CW+2){q_tok.number[31]}}, q_tok.number};
    if (ne > $signed({34'd0, CMAX})) num_c = CMAX;
    else if (ne < $signed({{34{1'b1}}, CMIN})) num_c = CMIN;
    else num_c = ne[CW-1:0];
  end

  // Room for two results: nothing pending in the spill and output drains or is free.
  logic room;
  assign room   = !spill_v && (!ob_v || !out_stall);
  assign q_take = q_valid && room;

  logic [1:0]           nres;
  res_t                 r0, r1;
  logic signed [CW-1:0] ncur_x, ncur_y, nctl_x, nctl_y, nst_x, nst_y;
  logic [3:0]  nact_let, nprev_let;
  logic        nact_rel, nact_on, nprev_on, nprev_rel, nfig, nhalt, clr, wr_arg;
  logic [2:0]  ngath, widx;

  always_comb begin
    logic [3:0] ltr;
    logic       rel, qsm, csm;
    logic signed [CW-1:0] ex, ey, ax, ay, bx, by;
    res_t       seg;
    nres = 2'd0; r0 = '0; r1 = '0;
    ncur_x = cur_x; ncur_y = cur_y; nctl_x = ctl_x; nctl_y = ctl_y;
    nst_x = st_x; nst_y = st_y;
    nact_let = act_let; nact_rel = act_rel; nact_on = act_on;
    nprev_let = prev_let; nprev_rel = prev_rel; nprev_on = prev_on;
    nfig = in_fig; nhalt = halted; ngath = gathered; clr = 1'b0;
    wr_arg = 1'b0; widx = 3'd0;
    ltr = act_let; rel = act_rel;
    ex = '0; ey = '0; ax = '0; ay = '0; bx = '0; by = '0; seg = '0;
    qsm = 1'b0; csm = 1'b0;
    case (q_tok.op)
      OP_END: begin
        if (!halted && act_on) begin
          r0 = mk(KIND_ERROR); r1 = mk(KIND_DONE); nres = 2'd2;
        end else if (!halted && in_fig) begin
          r0 = mk(KIND_OPEN); r1 = mk(KIND_DONE); nres = 2'd2;
        end else begin
          r0 = mk(KIND_DONE); nres = 2'd1;
        end
        clr = 1'b1;
      end
      OP_LETTER: begin
        if (!halted) begin
          if (q_tok.letter > LET_Z || act_on) begin
            r0 = mk(KIND_ERROR); nres = 2'd1; nhalt = 1'b1;
          end else if (q_tok.letter == LET_Z) begin
            if (in_fig) begin
              r0 = mk(KIND_CLOSED); nres = 2'd1; nfig = 1'b0;
              ncur_x = st_x; ncur_y = st_y;
            end
            nprev_on = 1'b1; nprev_let = LET_Z; nprev_rel = q_tok.relative;
          end else begin
            nact_on = 1'b1; nact_let = q_tok.letter; nact_rel = q_tok.relative;
            ngath = 3'd0;
          end
        end
      end
      OP_NUMBER: begin
        if (!halted) begin
          if (!act_on && (!prev_on || prev_let == LET_Z)) begin
            r0 = mk(KIND_ERROR); nres = 2'd1; nhalt = 1'b1;
          end else begin
            if (!act_on) begin
              ltr = (prev_let == LET_M) ? LET_L : prev_let;
              rel = prev_rel;
            end
            widx = act_on ? gathered : 3'd0;
            wr_arg = 1'b1;
            if (widx + 3'd1 < arg_need(ltr)) begin
              nact_on = 1'b1; nact_let = ltr; nact_rel = rel; ngath = widx + 3'd1;
            end else begin
              // Final argument: execute using stored args plus the incoming number.
              ax = reladd((widx == 3'd0) ? num_c : args[0], cur_x, rel);
              ay = reladd((widx == 3'd1) ? num_c : args[1], cur_y, rel);
              bx = reladd(args[2], cur_x, rel);
              by = reladd((widx == 3'd3) ? num_c : args[3], cur_y, rel);
              qsm = prev_on && (prev_let == LET_Q || prev_let == LET_T);
              csm = prev_on && (prev_let == LET_C || prev_let == LET_S);
              case (ltr)
                LET_M: begin
                  ex = ax; ey = ay;
                  seg = mk(KIND_BEGIN);
                  nfig = 1'b1; nst_x = ex; nst_y = ey;
                end
                LET_L: begin ex = ax; ey = ay; seg = mk(KIND_LINE); end
                LET_H: begin ex = ax; ey = cur_y; seg = mk(KIND_LINE); end
                LET_V: begin
                  ex = cur_x; ey = reladd(num_c, cur_y, rel); seg = mk(KIND_LINE);
                end
                LET_Q: begin
                  ex = bx; ey = by; seg = mk(KIND_QUAD);
                  seg.x0 = lo32(ax); seg.y0 = lo32(ay);
                  nctl_x = ax; nctl_y = ay;
                end
                LET_T: begin
                  ex = ax; ey = ay; seg = mk(KIND_QUAD);
                  nctl_x = qsm ? refl(cur_x, ctl_x) : cur_x;
                  nctl_y = qsm ? refl(cur_y, ctl_y) : cur_y;
                  seg.x0 = lo32(nctl_x); seg.y0 = lo32(nctl_y);
                end
                LET_C: begin
                  ex = reladd(args[4], cur_x, rel); ey = reladd(num_c, cur_y, rel);
                  seg = mk(KIND_CUBIC);
                  seg.x0 = lo32(ax); seg.y0 = lo32(ay);
                  seg.x1 = lo32(bx); seg.y1 = lo32(by);
                  nctl_x = bx; nctl_y = by;
                end
                LET_S: begin
                  ex = bx; ey = by; seg = mk(KIND_CUBIC);
                  seg.x0 = lo32(csm ? refl(cur_x, ctl_x) : cur_x);
                  seg.y0 = lo32(csm ? refl(cur_y, ctl_y) : cur_y);
                  seg.x1 = lo32(ax); seg.y1 = lo32(ay);
                  nctl_x = ax; nctl_y = ay;
                end
                default: begin
                  ex = reladd(args[5], cur_x, rel); ey = reladd(num_c, cur_y, rel);
                  seg = mk(KIND_ARC);
                  seg.x0 = lo32(args[0]); seg.y0 = lo32(args[1]);
                  seg.x1 = lo32(args[2]);
                  seg.la = (args[3] != '0); seg.sw = (args[4] != '0);
                end
              endcase
              seg.x2 = lo32(ex); seg.y2 = lo32(ey);
              if (ltr == LET_M && in_fig) begin
                r0 = mk(KIND_OPEN); r1 = seg; nres = 2'd2;
              end else begin
                r0 = seg; nres = 2'd1;
              end
              ncur_x = ex; ncur_y = ey;
              nprev_on = 1'b1; nprev_let = ltr; nprev_rel = rel;
              nact_on = 1'b0; ngath = 3'd0;
            end
          end
        end
      end
      default: ;
    endcase
    if (nres == 2'd1) r0.last = 1'b1;
    if (nres == 2'd2) r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_take && wr_arg) begin
      args[widx] <= num_c;
    end
    if (q_take && nres != 2'd0) begin
      ob    <= r0;
      spill <= r1;
    end else if (spill_v && !out_stall) begin
      ob <= spill;
    end
    if (rst) begin
      ob_v <= 1'b0; spill_v <= 1'b0;
      cur_x <= '0; cur_y <= '0; ctl_x <= '0; ctl_y <= '0; st_x <= '0; st_y <= '0;
      act_on <= 1'b0; prev_on <= 1'b0; act_let <= LET_M; prev_let <= LET_M;
      act_rel <= 1'b0; prev_rel <= 1'b0;
      gathered <= 3'd0; in_fig <= 1'b0; halted <= 1'b0;
    end else begin
      if (q_take && nres != 2'd0) begin
        ob_v <= 1'b1; spill_v <= (nres == 2'd2);
      end else if (!out_stall) begin
        ob_v <= spill_v; spill_v <= 1'b0;
      end
      if (q_take) begin
        if (clr) begin
          cur_x <= '0; cur_y <= '0; ctl_x <= '0; ctl_y <= '0; st_x <= '0; st_y <= '0;
          act_on <= 1'b0; prev_on <= 1'b0; gathered <= 3'd0;
          in_fig <= 1'b0; halted <= 1'b0;
        end else begin
          cur_x <= ncur_x; cur_y <= ncur_y; ctl_x <= nctl_x; ctl_y <= nctl_y;
          st_x <= nst_x; st_y <= nst_y;
          act_on <= nact_on; act_let <= nact_let; act_rel <= nact_rel;
          prev_on <= nprev_on; prev_let <= nprev_let; prev_rel <= nprev_rel;
          gathered <= ngath; in_fig <= nfig; halted <= nhalt;
        end
      end
    end
  end

  assign out_valid = ob_v;
  assign kind      = ob.kind;
  assign x0        = ob.x0;
  assign y0        = ob.y0;
  assign x1        = ob.x1;
  assign y1        = ob.y1;
  assign x2        = ob.x2;
  assign y2        = ob.y2;
  assign large_arc = ob.la;
  assign sweep     = ob.sw;
  assign last      = ob.last;

endmodule

// ----- rtl/core/vector_path_command_interpreter.sv -----
// Top level of the vector path command interpreter.
// Depends on vpci_pkg, vpci_front and vpci_back.
//
//   channel | direction | handshake          | payload
//   in      | in        | in_valid/in_stall  | op letter relative number
//   out     | out       | out_valid/out_stall| kind x0 y0 x1 y1 x2 y2 large_arc sweep last
//
// One token per cycle while nothing stalls; a token is registered in the queue before it executes.
// Tokens that make two results (end of figure plus begin, or end of figure or error
// plus done) hold the executor while the second word drains from the spill.
// Reset clears the path state; out_stall backs up through the queue.
module vector_path_command_interpreter #(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [3:0]  letter,
  input  logic        relative,
  input  logic [31:0] number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  kind,
  output logic [31:0] x0,
  output logic [31:0] y0,
  output logic [31:0] x1,
  output logic [31:0] y1,
  output logic [31:0] x2,
  output logic [31:0] y2,
  output logic        large_arc,
  output logic        sweep,
  output logic        last
);
  import vpci_pkg::*;

  token_t in_tok, q_tok;
  logic   q_valid, q_take;

  assign in_tok = '{op: op, letter: letter, relative: relative, number: number};

  vpci_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_tok,
    .q_valid, .q_take, .q_tok
  );

  vpci_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_tok,
    .out_valid, .out_stall, .kind, .x0, .y0, .x1, .y1, .x2, .y2,
    .large_arc, .sweep, .last
  );

endmodule

// ----- rtl/core/vpci_checker.sv -----
// Port-level checks for the vector path command interpreter, bound to the top level.
// Depends on vpci_pkg.
module vpci_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  kind,
  input logic [31:0] x0,
  input logic        large_arc,
  input logic        last
);
  import vpci_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(x0))
    else $error("stalled word changed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DONE |-> last)
    else $error("path done word is not last");

  a_flag_arc: assert property (@(posedge clk) disable iff (rst)
    out_valid && large_arc |-> kind == KIND_ARC)
    else $error("arc flag on non-arc word");

  a_no_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= KIND_ERROR)
    else $error("undefined result kind");

endmodule

bind vector_path_command_interpreter vpci_checker u_vpci_checker (
  .clk, .rst, .out_valid, .out_stall, .kind, .x0, .large_arc, .last
);
